// ----- design/ial_pkg.sv -----
// Shared types and constants for the iterative integer ALU.
// Used by ial_ctrl, ial_dp, iterative_integer_alu and the testbench; depends on nothing else.
`default_nettype none

package ial_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int KIND_WIDTH = 3;
    localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

    localparam logic [KIND_WIDTH-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SUB    = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_DIV    = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_MUL    = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_SQUARE = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_POWER  = 3'd5;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL_SETUP,
        DP_POW_SETUP,
        DP_POW_ROUND,
        DP_MUL_STEP,
        DP_POW_UPDATE,
        DP_DIV_SETUP,
        DP_DIV_STEP,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0] kind;
        logic                  div_err;
        logic                  exp_zero;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/ial_dp.sv -----
// Datapath of the iterative integer ALU: operand registers, two shift-add
// product lanes, the restoring divider step and the result register.
// Depends on ial_pkg.
`default_nettype none

module ial_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ial_pkg::dp_op_t                    cmd,
    input  wire logic [ial_pkg::KIND_WIDTH-1:0]     kind,
    input  wire logic [ial_pkg::DATA_WIDTH-1:0]     operand_a,
    input  wire logic [ial_pkg::DATA_WIDTH-1:0]     operand_b,
    output ial_pkg::dp_status_t                     stat,
    output logic                                    done,
    output logic [ial_pkg::DATA_WIDTH-1:0]          result,
    output logic                                    status
);
    import ial_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [KIND_WIDTH-1:0] kind_reg, kind_next;
    logic [W-1:0] opa_reg, opa_next;
    logic [W-1:0] opb_reg, opb_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] sq_reg, sq_next;
    logic [W-1:0] exp_reg, exp_next;
    logic [W-1:0] mc_reg, mc_next;
    logic [W-1:0] mr_reg, mr_next;
    logic [W-1:0] pa_reg, pa_next;
    logic [W-1:0] sc_reg, sc_next;
    logic [W-1:0] sr_reg, sr_next;
    logic [W-1:0] pb_reg, pb_next;
    logic [W-1:0] result_reg, result_next;
    logic         status_reg, status_next;
    logic         done_reg;

    logic         div_err;
    logic         exp_nonpos;
    logic [W-1:0] trial;

    assign div_err    = (opb_reg == '0) || opa_reg[W-1] || opb_reg[W-1];
    assign exp_nonpos = (opb_reg == '0) || opb_reg[W-1];
    assign trial      = {pa_reg[W-2:0], mc_reg[W-1]};

    assign stat.kind     = kind_reg;
    assign stat.div_err  = div_err;
    assign stat.exp_zero = (exp_reg == '0);

    always_comb
    begin
        kind_next   = kind_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        exp_next    = exp_reg;
        mc_next     = mc_reg;
        mr_next     = mr_reg;
        pa_next     = pa_reg;
        sc_next     = sc_reg;
        sr_next     = sr_reg;
        pb_next     = pb_reg;
        result_next = result_reg;
        status_next = status_reg;
        case (cmd)
            DP_LOAD:
            begin
                kind_next = kind;
                opa_next  = operand_a;
                opb_next  = operand_b;
            end
            DP_MUL_SETUP:
            begin
                mc_next = opa_reg;
                mr_next = (kind_reg == KIND_SQUARE) ? opa_reg : opb_reg;
                pa_next = '0;
                sc_next = '0;
                sr_next = '0;
                pb_next = '0;
            end
            DP_POW_SETUP:
            begin
                acc_next = W'(1);
                sq_next  = opa_reg;
                exp_next = exp_nonpos ? '0 : opb_reg;
            end
            DP_POW_ROUND:
            begin
                mc_next = acc_reg;
                mr_next = sq_reg;
                pa_next = '0;
                sc_next = sq_reg;
                sr_next = sq_reg;
                pb_next = '0;
            end
            DP_MUL_STEP:
            begin
                pa_next = mr_reg[0] ? pa_reg + mc_reg : pa_reg;
                mc_next = {mc_reg[W-2:0], 1'b0};
                mr_next = {1'b0, mr_reg[W-1:1]};
                pb_next = sr_reg[0] ? pb_reg + sc_reg : pb_reg;
                sc_next = {sc_reg[W-2:0], 1'b0};
                sr_next = {1'b0, sr_reg[W-1:1]};
            end
            DP_POW_UPDATE:
            begin
                if (exp_reg[0])
                begin
                    acc_next = pa_reg;
                end
                sq_next  = pb_reg;
                exp_next = {1'b0, exp_reg[W-1:1]};
            end
            DP_DIV_SETUP:
            begin
                pa_next = '0;
                mc_next = opa_reg;
                mr_next = opb_reg;
            end
            DP_DIV_STEP:
            begin
                if (trial >= mr_reg)
                begin
                    pa_next = trial - mr_reg;
                    mc_next = {mc_reg[W-2:0], 1'b1};
                end
                else
                begin
                    pa_next = trial;
                    mc_next = {mc_reg[W-2:0], 1'b0};
                end
            end
            DP_FINISH:
            begin
                status_next = 1'b0;
                case (kind_reg)
                    KIND_ADD:    result_next = opa_reg + opb_reg;
                    KIND_SUB:    result_next = opa_reg - opb_reg;
                    KIND_DIV:
                    begin
                        result_next = div_err ? '0 : mc_reg;
                        status_next = div_err;
                    end
                    KIND_MUL,
                    KIND_SQUARE: result_next = pa_reg;
                    KIND_POWER:  result_next = acc_reg;
                    default:     result_next = '0;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        mc_reg     <= mc_next;
        mr_reg     <= mr_next;
        pa_reg     <= pa_next;
        sc_reg     <= sc_next;
        sr_reg     <= sr_next;
        pb_reg     <= pb_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd == DP_FINISH);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// ----- design/ial_ctrl.sv -----
// Controller of the iterative integer ALU: sequences the datapath commands
// and counts the bit steps of multiply and divide. Depends on ial_pkg.
`default_nettype none

module ial_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire ial_pkg::dp_status_t stat,
    output ial_pkg::dp_op_t          cmd,
    output logic                     busy
);
    import ial_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_DIV,
        S_POW_CHECK,
        S_POW_MUL,
        S_POW_UPDATE,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = DP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                case (stat.kind)
                    KIND_MUL,
                    KIND_SQUARE:
                    begin
                        cmd        = DP_MUL_SETUP;
                        state_next = S_MUL;
                    end
                    KIND_DIV:
                    begin
                        if (stat.div_err)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd        = DP_DIV_SETUP;
                            state_next = S_DIV;
                        end
                    end
                    KIND_POWER:
                    begin
                        cmd        = DP_POW_SETUP;
                        state_next = S_POW_CHECK;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd      = DP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                cmd      = DP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_POW_CHECK:
            begin
                cnt_next = '0;
                if (stat.exp_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = DP_POW_ROUND;
                    state_next = S_POW_MUL;
                end
            end
            S_POW_MUL:
            begin
                cmd      = DP_MUL_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_POW_UPDATE;
                end
            end
            S_POW_UPDATE:
            begin
                cmd        = DP_POW_UPDATE;
                state_next = S_POW_CHECK;
            end
            S_FINISH:
            begin
                cmd        = DP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- design/iterative_integer_alu.sv -----
// Top level of the iterative integer ALU: joins the controller and the datapath.
// Depends on ial_pkg, ial_ctrl and ial_dp.
//
// Usage: drive kind, operand_a and operand_b and raise start; the transfer
// takes place at the rising edge where start is high and busy is low. Busy
// then stays high until the result is delivered. Each item gives exactly one
// result: result and status are valid for the single cycle in which done is
// high, and the receiver must take them then, as it cannot stall the block.
// Steps from the accepting edge to the done cycle:
//   add, subtract, unused kinds and division errors: load, dispatch, finish;
//   multiply, square and divide: load, dispatch, then one operand bit per cycle in the
//   shift-add or restoring shift-subtract unit, then finish;
//   power: load, dispatch, one round for each bit of a positive exponent up
//   to its highest set bit (none for an exponent that is not positive), then
//   a last check and finish; each round is a check, 32 shift-add steps and
//   an update, running the lanes for the accumulator and the square in
//   parallel.
// Busy falls in the done cycle, so a new item may be started then.
// Reset clears the controller and the done strobe; the block is idle after it.
`default_nettype none

module iterative_integer_alu (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [ial_pkg::KIND_WIDTH-1:0]        kind,
    input  wire logic signed [ial_pkg::DATA_WIDTH-1:0] operand_a,
    input  wire logic signed [ial_pkg::DATA_WIDTH-1:0] operand_b,
    output logic                                       done,
    output logic signed [ial_pkg::DATA_WIDTH-1:0]      result,
    output logic                                       status
);
    import ial_pkg::*;

    dp_op_t                  cmd;
    dp_status_t              stat;
    logic [DATA_WIDTH-1:0]   result_u;

    ial_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ial_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .stat      (stat),
        .done      (done),
        .result    (result_u),
        .status    (status)
    );

    assign result = signed'(result_u);

endmodule

`default_nettype wire

// ----- test/alu_checker.sv -----
// Checker for the iterative integer ALU: watches the operation and result channels,
// predicts each result and compares it with what the block delivers.
// Depends on ial_pkg only.
module alu_checker
    import ial_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [KIND_WIDTH-1:0]        kind,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    input  logic                         done,
    input  logic signed [DATA_WIDTH-1:0] result,
    input  logic                         status,
    output int                           failures,
    output int                           outstanding,
    output int                           checked,
    output int                           div_errors
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  flag;
    } alu_answer_t;

    alu_answer_t answers[$];

    function automatic alu_answer_t compute_alu(input logic [KIND_WIDTH-1:0] op,
                                                input logic [DATA_WIDTH-1:0] a,
                                                input logic [DATA_WIDTH-1:0] b);
        alu_answer_t           ans;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] sq;
        ans.value = '0;
        ans.flag  = 1'b0;
        case (op)
            KIND_ADD:    ans.value = a + b;
            KIND_SUB:    ans.value = a - b;
            KIND_DIV:
            begin
                if (b == '0 || a[DATA_WIDTH-1] || b[DATA_WIDTH-1])
                    ans.flag = 1'b1;
                else
                    ans.value = a / b;
            end
            KIND_MUL:    ans.value = a * b;
            KIND_SQUARE: ans.value = a * a;
            KIND_POWER:
            begin
                acc = 1;
                sq  = a;
                if (!b[DATA_WIDTH-1] && b != '0)
                begin
                    for (int i = 0; i < DATA_WIDTH; i++)
                    begin
                        if (b[i])
                            acc = acc * sq;
                        sq = sq * sq;
                    end
                end
                ans.value = acc;
            end
            default:     ans.value = '0;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin
        alu_answer_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Result %h status %b arrived with no transfer outstanding.",
                                 result, status);
                end
                else
                begin
                    want = answers.pop_front();
                    checked++;
                    if (want.flag)
                        div_errors++;
                    if (result !== want.value || status !== want.flag)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("Mismatch: expected result %h status %b, got %h status %b.",
                                     want.value, want.flag, result, status);
                    end
                end
            end
            if (start && !busy)
                answers.push_back(compute_alu(kind, operand_a, operand_b));
            outstanding = answers.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for the iterative integer ALU: drives directed and random operations
// with random gaps and gives the verdict. Depends on ial_pkg, alu_checker and the block.
module tb;
    import ial_pkg::*;

    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_SPARE_HI = 3'd7;
    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MAX = ~WORD_MIN;
    localparam int RANDOM_ITEMS = 800;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [KIND_WIDTH-1:0]        kind;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] result;
    logic                         status;
    int                           failures;
    int                           outstanding;
    int                           checked;
    int                           div_errors;
    bit                           gaps_enabled;

    iterative_integer_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .result    (result),
        .status    (status)
    );

    alu_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .done        (done),
        .result      (result),
        .status      (status),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked),
        .div_errors  (div_errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [DATA_WIDTH-1:0] any_word();
        case ($urandom_range(0, 13))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            4:       return DATA_WIDTH'($urandom_range(0, 300));
            5:       return -DATA_WIDTH'($urandom_range(1, 300));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [KIND_WIDTH-1:0] op,
                           input logic [DATA_WIDTH-1:0] a,
                           input logic [DATA_WIDTH-1:0] b);
        if (gaps_enabled && $urandom_range(0, 99) < 17)
        begin
            start     <= 1'b0;
            operand_a <= $urandom;
            operand_b <= $urandom;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic [KIND_WIDTH-1:0] op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        int                    roll;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_ADD;
        operand_a    = '0;
        operand_b    = '0;
        gaps_enabled = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(KIND_ADD, WORD_MAX, 1);
        send_op(KIND_ADD, WORD_MIN, '1);
        send_op(KIND_SUB, WORD_MIN, 1);
        send_op(KIND_SUB, '0, WORD_MIN);
        send_op(KIND_DIV, 7, '0);
        send_op(KIND_DIV, -7, 3);
        send_op(KIND_DIV, 7, -3);
        send_op(KIND_DIV, '0, 5);
        send_op(KIND_DIV, WORD_MAX, 1);
        send_op(KIND_DIV, WORD_MAX, WORD_MAX);
        send_op(KIND_DIV, 100, 7);
        send_op(KIND_MUL, WORD_MIN, '1);
        send_op(KIND_MUL, WORD_MAX, WORD_MAX);
        send_op(KIND_SQUARE, WORD_MIN, $urandom);
        send_op(KIND_SQUARE, '1, '0);
        send_op(KIND_POWER, 5, '0);
        send_op(KIND_POWER, 5, -3);
        send_op(KIND_POWER, '0, 7);
        send_op(KIND_POWER, 3, WORD_MAX);
        send_op(KIND_POWER, '1, WORD_MIN);
        send_op(KIND_POWER, WORD_MIN, 1);
        send_op(KIND_SPARE_LO, WORD_MAX, WORD_MAX);
        send_op(KIND_SPARE_HI, '1, '1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            gaps_enabled = !(i >= 300 && i < 500);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = (roll < 2) ? KIND_SPARE_LO : KIND_SPARE_HI;
            else
                op = KIND_WIDTH'($urandom_range(KIND_ADD, KIND_POWER));
            a = any_word();
            b = any_word();
            case (op)
                KIND_DIV:
                begin
                    if ($urandom_range(0, 99) < 80)
                    begin
                        a = {1'b0, a[DATA_WIDTH-2:0]};
                        b = {1'b0, b[DATA_WIDTH-2:0]} >> $urandom_range(0, DATA_WIDTH - 2);
                        if (b == '0)
                            b = 1;
                    end
                end
                KIND_POWER:
                begin
                    roll = $urandom_range(0, 9);
                    if (roll == 2)
                        b = '0;
                    else if (roll > 2)
                        b = DATA_WIDTH'($urandom_range(1, 4095));
                end
                default: ;
            endcase
            send_op(op, a, b);
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results, %0d of them division errors, over every operation,",
                 checked, div_errors);
        $display("the unused kinds, operand extremes and random gaps between transfers.");
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- iterative_integer_alu.f -----
design/ial_pkg.sv
design/ial_dp.sv
design/ial_ctrl.sv
design/iterative_integer_alu.sv
test/alu_checker.sv
test/tb.sv
